[rtl/sapd_pkg.sv]
// ----------------------------------------------------------------------------
// sapd_pkg
// Types, codes and helpers shared by the scratchpad manager files.
// ----------------------------------------------------------------------------
package sapd_pkg;

  typedef logic [15:0] block_id_t;
  typedef logic [20:0] bytes_t;
  typedef logic [24:0] energy_t;
  typedef logic [31:0] stamp_t;

  typedef enum logic [1:0] {
    REQ_STORE   = 2'd0,
    REQ_ACQUIRE = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_DELETE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KIND_EVICTED   = 3'd0,
    KIND_ACQUIRED  = 3'd1,
    KIND_STORED    = 3'd2,
    KIND_REFRESHED = 3'd3,
    KIND_RELEASED  = 3'd4,
    KIND_TOO_BIG   = 3'd5,
    KIND_ABSENT    = 3'd6
  } kind_e;

  localparam bytes_t CAP_RESET = 21'd65536;
  // 8 bits per byte at 2 pJ per bit
  localparam int unsigned ENERGY_SHIFT = 4;

  typedef struct packed {
    block_id_t blk;
    bytes_t    size;
    stamp_t    stamp;
  } slot_entry_t;

  typedef struct packed {
    logic      hit;
    bytes_t    hit_size;
    logic      free_found;
    logic      vic_found;
    block_id_t vic_block;
    bytes_t    vic_size;
  } scan_res_t;

  function automatic energy_t energy_of(bytes_t b);
    return energy_t'(b) << ENERGY_SHIFT;
  endfunction

endpackage

[rtl/sapd_req_if.sv]
// ----------------------------------------------------------------------------
// sapd_req_if
// Request channel: one item per store, acquire, release or delete.
// ----------------------------------------------------------------------------
interface sapd_req_if;
  logic                valid;
  logic                ready;
  sapd_pkg::req_e      req_type;
  sapd_pkg::block_id_t block_id;
  sapd_pkg::bytes_t    block_size;

  modport source (output valid, output req_type, output block_id, output block_size,
                  input ready);
  modport sink   (input valid, input req_type, input block_id, input block_size,
                  output ready);
endinterface

[rtl/sapd_res_if.sv]
// ----------------------------------------------------------------------------
// sapd_res_if
// Result channel: one item per eviction or request outcome.
// ----------------------------------------------------------------------------
interface sapd_res_if;
  logic                valid;
  logic                ready;
  sapd_pkg::kind_e     kind;
  sapd_pkg::block_id_t out_block_id;
  sapd_pkg::bytes_t    out_block_size;
  sapd_pkg::energy_t   energy_pj;
  sapd_pkg::bytes_t    used_after;
  logic                last;

  modport source (output valid, output kind, output out_block_id, output out_block_size,
                  output energy_pj, output used_after, output last, input ready);
  modport sink   (input valid, input kind, input out_block_id, input out_block_size,
                  input energy_pj, input used_after, input last, output ready);
endinterface

[rtl/size_aware_lru_scratchpad_unit.sv]
// ----------------------------------------------------------------------------
// size_aware_lru_scratchpad_unit
// Size-aware LRU scratchpad manager. A request takes one slot-table scan
// plus one more scan per eviction. Scan rate is set by the single slot
// memory read port. The result register lets the next item enter while a
// result waits. Reset clears all slot valid bits, used bytes and the request
// clock; capacity returns to 65536; the slot memory itself is not cleared.
// ----------------------------------------------------------------------------
module size_aware_lru_scratchpad_unit #(
  parameter int unsigned SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  sapd_pkg::bytes_t cfg_wdata_i,
  sapd_req_if.sink         req_i,
  sapd_res_if.source       res_o
);
  import sapd_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DECIDE
  } state_e;

  state_e        state_q;
  req_e          req_q;
  block_id_t     id_q;
  bytes_t        size_q;
  bytes_t        cap_q;
  bytes_t        used_q;
  stamp_t        clock_q;
  logic [SLOTS-1:0] valid_q;
  logic [IW-1:0] addr_q;

  logic          rd_act_q, rd_vld_q;
  logic [IW-1:0] rd_idx_q;

  logic          out_vld_q;
  kind_e         out_kind_q;
  block_id_t     out_blk_q;
  bytes_t        out_size_q;
  energy_t       out_energy_q;
  bytes_t        out_used_q;
  logic          out_last_q;

  slot_entry_t   rdata;
  scan_res_t     sres;
  logic [IW-1:0] hit_idx, free_idx, vic_idx;

  logic          in_acc, out_free, go, scan_clear;
  logic          ins, need_evict, too_big;
  logic [21:0]   fit_sum;

  kind_e         dec_kind;
  block_id_t     dec_blk;
  bytes_t        dec_size;
  energy_t       dec_energy;
  bytes_t        dec_used;
  logic          dec_last, dec_evict;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  slot_entry_t   mem_wdata;
  logic          set_vld, clr_vld;
  logic [IW-1:0] vld_idx;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || res_o.ready;
  assign go          = (state_q == S_DECIDE) && out_free;
  assign scan_clear  = in_acc || (go && dec_evict);

  sapd_slot_ram #(.DEPTH(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  sapd_scan #(.SLOTS(SLOTS)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (scan_clear),
    .step_i     (rd_act_q),
    .idx_i      (rd_idx_q),
    .slot_vld_i (rd_vld_q),
    .entry_i    (rdata),
    .id_i       (id_q),
    .now_i      (clock_q),
    .res_o      (sres),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .vic_idx_o  (vic_idx)
  );

  // read pipeline, aligned with registered memory data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_act_q <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      rd_act_q <= (state_q == S_SCAN);
      rd_vld_q <= valid_q[addr_q];
      rd_idx_q <= addr_q;
    end
  end

  assign ins        = (req_q == REQ_STORE) || (req_q == REQ_ACQUIRE);
  assign fit_sum    = {1'b0, used_q} + {1'b0, size_q};
  assign need_evict = (fit_sum > {1'b0, cap_q}) || !sres.free_found;
  assign too_big    = size_q > cap_q;

  always_comb begin
    dec_kind   = KIND_ABSENT;
    dec_blk    = id_q;
    dec_size   = size_q;
    dec_energy = '0;
    dec_used   = used_q;
    dec_last   = 1'b1;
    dec_evict  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = hit_idx;
    mem_wdata  = '{blk: id_q, size: size_q, stamp: clock_q};
    set_vld    = 1'b0;
    clr_vld    = 1'b0;
    vld_idx    = hit_idx;
    if (ins) begin
      if (sres.hit) begin
        dec_kind       = KIND_REFRESHED;
        dec_size       = sres.hit_size;
        mem_we         = 1'b1;
        mem_wdata.size = sres.hit_size;
      end else if (too_big) begin
        dec_kind = KIND_TOO_BIG;
      end else if (need_evict && sres.vic_found) begin
        dec_kind   = KIND_EVICTED;
        dec_blk    = sres.vic_block;
        dec_size   = sres.vic_size;
        dec_energy = energy_of(sres.vic_size);
        dec_used   = used_q - sres.vic_size;
        dec_last   = 1'b0;
        dec_evict  = 1'b1;
        clr_vld    = 1'b1;
        vld_idx    = vic_idx;
      end else begin
        if (req_q == REQ_ACQUIRE) begin
          dec_kind   = KIND_ACQUIRED;
          dec_energy = energy_of(size_q);
        end else begin
          dec_kind = KIND_STORED;
        end
        if (sres.free_found) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
          set_vld   = 1'b1;
          vld_idx   = free_idx;
          dec_used  = used_q + size_q;
        end
      end
    end else if (sres.hit) begin
      dec_kind   = KIND_RELEASED;
      dec_size   = sres.hit_size;
      dec_energy = (req_q == REQ_RELEASE) ? energy_of(sres.hit_size) : '0;
      dec_used   = used_q - sres.hit_size;
      clr_vld    = 1'b1;
    end
    if (!go) begin
      mem_we  = 1'b0;
      set_vld = 1'b0;
      clr_vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= REQ_STORE;
      id_q         <= '0;
      size_q       <= '0;
      cap_q        <= CAP_RESET;
      used_q       <= '0;
      clock_q      <= '0;
      valid_q      <= '0;
      addr_q       <= '0;
      out_vld_q    <= 1'b0;
      out_kind_q   <= KIND_EVICTED;
      out_blk_q    <= '0;
      out_size_q   <= '0;
      out_energy_q <= '0;
      out_used_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (set_vld) begin
        valid_q[vld_idx] <= 1'b1;
      end
      if (clr_vld) begin
        valid_q[vld_idx] <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q   <= req_i.req_type;
            id_q    <= req_i.block_id;
            size_q  <= req_i.block_size;
            addr_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (addr_q == LAST_IDX) begin
            state_q <= S_WAIT;
          end else begin
            addr_q <= addr_q + IW'(1);
          end
        end
        S_WAIT: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (go) begin
            out_vld_q    <= 1'b1;
            out_kind_q   <= dec_kind;
            out_blk_q    <= dec_blk;
            out_size_q   <= dec_size;
            out_energy_q <= dec_energy;
            out_used_q   <= dec_used;
            out_last_q   <= dec_last;
            used_q       <= dec_used;
            if (dec_evict) begin
              addr_q  <= '0;
              state_q <= S_SCAN;
            end else begin
              clock_q <= clock_q + 32'd1;
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.kind           = out_kind_q;
  assign res_o.out_block_id   = out_blk_q;
  assign res_o.out_block_size = out_size_q;
  assign res_o.energy_pj      = out_energy_q;
  assign res_o.used_after     = out_used_q;
  assign res_o.last           = out_last_q;

endmodule

[rtl/sapd_slot_ram.sv]
// ----------------------------------------------------------------------------
// sapd_slot_ram
// Slot table memory: block id, size and stamp, one write and one read port.
// ----------------------------------------------------------------------------
module sapd_slot_ram #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  sapd_pkg::slot_entry_t wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output sapd_pkg::slot_entry_t rdata_o
);
  import sapd_pkg::*;

  slot_entry_t mem [DEPTH];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sapd_scan.sv]
// ----------------------------------------------------------------------------
// sapd_scan
// Slot scanner: one entry per step, tracks id match, first free slot and
// the oldest valid slot (lowest index on equal age).
// ----------------------------------------------------------------------------
module sapd_scan #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  step_i,
  input  logic [IW-1:0]         idx_i,
  input  logic                  slot_vld_i,
  input  sapd_pkg::slot_entry_t entry_i,
  input  sapd_pkg::block_id_t   id_i,
  input  sapd_pkg::stamp_t      now_i,
  output sapd_pkg::scan_res_t   res_o,
  output logic [IW-1:0]         hit_idx_o,
  output logic [IW-1:0]         free_idx_o,
  output logic [IW-1:0]         vic_idx_o
);
  import sapd_pkg::*;

  logic      hit_q, free_q, vic_q;
  logic      hit_d, free_d, vic_d;
  logic [IW-1:0] hit_idx_q, free_idx_q, vic_idx_q;
  bytes_t    hit_size_q, vic_size_q;
  block_id_t vic_block_q;
  stamp_t    vic_age_q;
  stamp_t    age;
  logic      take_hit, take_free, take_vic;

  assign age       = now_i - entry_i.stamp;
  assign take_hit  = step_i && slot_vld_i && !hit_q && (entry_i.blk == id_i);
  assign take_free = step_i && !slot_vld_i && !free_q;
  assign take_vic  = step_i && slot_vld_i && (!vic_q || (age > vic_age_q));

  assign hit_d  = !clear_i && (hit_q || take_hit);
  assign free_d = !clear_i && (free_q || take_free);
  assign vic_d  = !clear_i && (vic_q || take_vic);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      vic_q  <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      free_q <= free_d;
      vic_q  <= vic_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q  <= idx_i;
      hit_size_q <= entry_i.size;
    end
    if (take_free) begin
      free_idx_q <= idx_i;
    end
    if (take_vic) begin
      vic_idx_q   <= idx_i;
      vic_block_q <= entry_i.blk;
      vic_size_q  <= entry_i.size;
      vic_age_q   <= age;
    end
  end

  assign res_o.hit        = hit_q;
  assign res_o.hit_size   = hit_size_q;
  assign res_o.free_found = free_q;
  assign res_o.vic_found  = vic_q;
  assign res_o.vic_block  = vic_block_q;
  assign res_o.vic_size   = vic_size_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign vic_idx_o  = vic_idx_q;

endmodule

[test/size_aware_lru_scratchpad_unit_test.sv]
// ----------------------------------------------------------------------------
// size_aware_lru_scratchpad_unit_test
// Self-checking bench for the scratchpad manager. A cycle-free model of the
// slot table predicts every eviction and outcome for each accepted request.
// A scoreboard compares each result item in order. Directed requests come
// first, then random phases over several capacities. The phases use random
// idle cycles on both channels, one phase without idling, and one long
// result hold-off.
// ----------------------------------------------------------------------------
module size_aware_lru_scratchpad_unit_test;
  import sapd_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned MAX_BYTES    = 1048576;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned PHASE_ITEMS  = 90;
  localparam int unsigned SETTLE_CYCLES = 2 * (SLOTS + 3);
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    kind_e     kind;
    block_id_t blk;
    bytes_t    nbytes;
    energy_t   energy;
    bytes_t    used;
    logic      last;
  } outcome_t;

  class lru_scoreboard;
    bit          slot_busy[SLOTS];
    block_id_t   slot_blk[SLOTS];
    bytes_t      slot_bytes[SLOTS];
    stamp_t      slot_stamp[SLOTS];
    int unsigned used_bytes;
    stamp_t      req_clock;
    int unsigned capacity;
    outcome_t    outcome_q[$];
    int          errors;

    function new();
      foreach (slot_busy[i]) begin
        slot_busy[i]  = 1'b0;
        slot_blk[i]   = '0;
        slot_bytes[i] = '0;
        slot_stamp[i] = '0;
      end
      used_bytes = 0;
      req_clock  = '0;
      capacity   = CAP_RESET;
      errors     = 0;
    endfunction

    function void set_capacity(bytes_t v);
      capacity = v;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function energy_t move_energy(bytes_t b);
      int unsigned e;
      e = b * 16;
      return energy_t'(e);
    endfunction

    function void push(kind_e k, block_id_t id, bytes_t b, energy_t e);
      outcome_t o;
      o.kind   = k;
      o.blk    = id;
      o.nbytes = b;
      o.energy = e;
      o.used   = bytes_t'(used_bytes);
      o.last   = 1'b0;
      outcome_q.push_back(o);
    endfunction

    function int free_slot();
      for (int i = 0; i < SLOTS; i++)
        if (!slot_busy[i]) return i;
      return -1;
    endfunction

    function int lru_slot();
      int     best;
      stamp_t best_age;
      stamp_t age;
      best     = -1;
      best_age = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy[i]) begin
          age = req_clock - slot_stamp[i];
          if (best < 0 || age > best_age) begin
            best     = i;
            best_age = age;
          end
        end
      end
      return best;
    endfunction

    function void note_request(req_e op, block_id_t id, bytes_t sz);
      int hit;
      int victim;
      int slot;
      hit = -1;
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && slot_busy[i] && slot_blk[i] == id) hit = i;
      if (op == REQ_STORE || op == REQ_ACQUIRE) begin
        if (hit >= 0) begin
          slot_stamp[hit] = req_clock;
          push(KIND_REFRESHED, id, slot_bytes[hit], '0);
        end else if (sz > capacity) begin
          push(KIND_TOO_BIG, id, sz, '0);
        end else begin
          while (used_bytes + sz > capacity || free_slot() < 0) begin
            victim = lru_slot();
            if (victim < 0) break;
            slot_busy[victim] = 1'b0;
            used_bytes -= slot_bytes[victim];
            push(KIND_EVICTED, slot_blk[victim], slot_bytes[victim],
                 move_energy(slot_bytes[victim]));
          end
          slot = free_slot();
          if (slot >= 0) begin
            slot_busy[slot]  = 1'b1;
            slot_blk[slot]   = id;
            slot_bytes[slot] = sz;
            slot_stamp[slot] = req_clock;
            used_bytes += sz;
          end
          if (op == REQ_ACQUIRE) push(KIND_ACQUIRED, id, sz, move_energy(sz));
          else push(KIND_STORED, id, sz, '0);
        end
      end else begin
        if (hit < 0) begin
          push(KIND_ABSENT, id, sz, '0);
        end else begin
          slot_busy[hit] = 1'b0;
          used_bytes -= slot_bytes[hit];
          push(KIND_RELEASED, id, slot_bytes[hit],
               op == REQ_RELEASE ? move_energy(slot_bytes[hit]) : energy_t'(0));
        end
      end
      req_clock++;
      outcome_q[outcome_q.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("unexpected item kind %0d block %0h", got.kind, got.blk));
        return;
      end
      want = outcome_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.blk !== want.blk)
        report($sformatf("block %0h, want %0h", got.blk, want.blk));
      if (got.nbytes !== want.nbytes)
        report($sformatf("size %0d, want %0d", got.nbytes, want.nbytes));
      if (got.energy !== want.energy)
        report($sformatf("energy %0d, want %0d", got.energy, want.energy));
      if (got.used !== want.used)
        report($sformatf("used %0d, want %0d", got.used, want.used));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we_i;
  bytes_t cfg_wdata_i;

  sapd_req_if req_bus ();
  sapd_res_if res_bus ();

  size_aware_lru_scratchpad_unit #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_bus),
    .res_o      (res_bus)
  );

  lru_scoreboard sb;
  bit            src_idle_on;
  bit            sink_idle_on;
  int            hold_cycles;
  block_id_t     id_pool[POOL_SIZE];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1500000;
    $display("size_aware_lru_scratchpad_unit verification failed");
    $finish;
  end

  // result side
  initial begin
    outcome_t got;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready) begin
        got.kind   = res_bus.kind;
        got.blk    = res_bus.out_block_id;
        got.nbytes = res_bus.out_block_size;
        got.energy = res_bus.energy_pj;
        got.used   = res_bus.used_after;
        got.last   = res_bus.last;
        sb.check_result(got);
      end
      if (hold_cycles > 0) begin
        res_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (sink_idle_on && $urandom_range(0, 99) < 35) begin
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(req_e op, block_id_t id, bytes_t sz);
    if (src_idle_on && $urandom_range(0, 99) < 35) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 35);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= op;
    req_bus.block_id   <= id;
    req_bus.block_size <= sz;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(op, id, sz);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(bytes_t v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_capacity(v);
  endtask

  function automatic bytes_t pick_size(int unsigned cap);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 9) return bytes_t'(cap);
    if (r < 15) return bytes_t'(cap < MAX_BYTES ? $urandom_range(cap + 1, MAX_BYTES)
                                               : MAX_BYTES);
    if (r < 17) return bytes_t'(MAX_BYTES);
    if (r < 60) return bytes_t'($urandom_range(0, cap / 40 + 1));
    return bytes_t'($urandom_range(0, cap / 5 > 1 ? cap / 5 : 1));
  endfunction

  task automatic random_request();
    int unsigned r;
    req_e        op;
    block_id_t   id;
    r = $urandom_range(0, 99);
    if (r < 35)      op = REQ_STORE;
    else if (r < 65) op = REQ_ACQUIRE;
    else if (r < 83) op = REQ_RELEASE;
    else             op = REQ_DELETE;
    if ($urandom_range(0, 99) < 85) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    else id = block_id_t'($urandom);
    send_request(op, id, pick_size(sb.capacity));
  endtask

  initial begin
    int unsigned phase_cap[5];
    sb = new();
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_STORE;
    req_bus.block_id   = '0;
    req_bus.block_size = '0;
    src_idle_on        = 1'b1;
    sink_idle_on       = 1'b1;
    hold_cycles        = 0;
    phase_cap = '{1, 300, MAX_BYTES, $urandom_range(1, MAX_BYTES), 4096};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, at reset capacity
    send_request(REQ_STORE,   16'h0000, 21'd0);
    send_request(REQ_ACQUIRE, 16'hFFFF, 21'd65536);
    send_request(REQ_STORE,   16'h0001, 21'd100);
    send_request(REQ_STORE,   16'h0001, 21'd5);
    send_request(REQ_ACQUIRE, 16'h0001, 21'd0);
    send_request(REQ_STORE,   16'h0002, 21'd1048576);
    send_request(REQ_ACQUIRE, 16'h0003, 21'd65537);
    send_request(REQ_RELEASE, 16'h0001, 21'd0);
    send_request(REQ_DELETE,  16'h0001, 21'd77);
    send_request(REQ_RELEASE, 16'h0007, 21'd1048575);
    send_request(REQ_STORE,   16'h0003, 21'd10);
    send_request(REQ_DELETE,  16'h0003, 21'd0);
    send_request(REQ_ACQUIRE, 16'hA5A5, 21'd40000);
    send_request(REQ_STORE,   16'h5A5A, 21'd30000);

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_capacity(bytes_t'(phase_cap[p]));
      foreach (id_pool[i]) id_pool[i] = block_id_t'($urandom);
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      src_idle_on  = (p != 1);
      sink_idle_on = (p != 1);
      if (p == 2) hold_cycles = HOLD_CYCLES;
      repeat (PHASE_ITEMS) random_request();
    end
    wait_drained();

    if (sb.errors == 0) begin
      $display("size_aware_lru_scratchpad_unit verification clean");
    end else begin
      $display("size_aware_lru_scratchpad_unit verification failed");
    end
    $finish;
  end

endmodule

[size_aware_lru_scratchpad_unit.f]
rtl/sapd_pkg.sv
rtl/sapd_req_if.sv
rtl/sapd_res_if.sv
rtl/sapd_slot_ram.sv
rtl/sapd_scan.sv
rtl/size_aware_lru_scratchpad_unit.sv
test/size_aware_lru_scratchpad_unit_test.sv
